/* rtl/aesf_pkg.sv */
`timescale 1ns / 1ps

package aesf_pkg;

	typedef enum logic [2:0] {
		ST_PLAIN,
		ST_ESC,
		ST_CSI1,
		ST_CSI2,
		ST_SS,
		ST_NF,
		ST_STR,
		ST_STR2
	} parse_state_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] RC_BUSY  = 2'd0;
	localparam logic [1:0] RC_DONE  = 2'd1;
	localparam logic [1:0] RC_EMPTY = 2'd2;
	localparam logic [1:0] RC_TRUNC = 2'd3;

	localparam logic [7:0] CH_BEL     = 8'h07;
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SS2     = 8'h4E;
	localparam logic [7:0] CH_SS3     = 8'h4F;
	localparam logic [7:0] CH_DCS     = 8'h50;
	localparam logic [7:0] CH_SOS     = 8'h58;
	localparam logic [7:0] CH_CSI     = 8'h5B;
	localparam logic [7:0] CH_ST      = 8'h5C;
	localparam logic [7:0] CH_OSC     = 8'h5D;
	localparam logic [7:0] CH_PM      = 8'h5E;
	localparam logic [7:0] CH_APC     = 8'h5F;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_C1_LO   = 8'h80;
	localparam logic [7:0] CH_C1_ST   = 8'h9C;
	localparam logic [7:0] CH_UTF8_LO = 8'hC0;
	localparam logic [7:0] CH_C2_LEAD = 8'hC2;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} rx_word_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [15:0] seq_length;
		logic        restarted;
	} frame_word_t;

endpackage

/* rtl/aesf_step.sv */
`timescale 1ns / 1ps

module aesf_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  aesf_pkg::rx_word_t     word,
	input  aesf_pkg::parse_state_t state,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic                   second_esc,
	output aesf_pkg::parse_state_t state_next,
	output logic [COUNT_WIDTH-1:0] count_next,
	output logic                   second_esc_next,
	output aesf_pkg::frame_word_t  result
);
	import aesf_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);
	localparam logic [COUNT_WIDTH-1:0] CNT_3   = COUNT_WIDTH'(3);
	localparam logic [COUNT_WIDTH-1:0] CNT_4   = COUNT_WIDTH'(4);

	logic [7:0]             c;
	logic [COUNT_WIDTH-1:0] cnt;
	parse_state_t           ps;
	logic                   done;
	logic                   restart;
	logic [31:0]            cnt_ext;
	logic [15:0]            len;

	assign c = word.byte_value;

	// next state
	always_comb begin
		ps      = state;
		cnt     = (count != CNT_MAX) ? count + CNT_ONE : count;
		done    = 1'b0;
		restart = 1'b0;
		case (state)
			ST_PLAIN: begin
				if (c == CH_ESC) begin
					ps = ST_ESC;
				end else if (c < CH_C1_LO || c >= CH_UTF8_LO) begin
					done = 1'b1;
				end
			end
			ST_ESC: begin
				if (c inside {[CH_SP:8'h2F]}) begin
					if (c == CH_SP || c == CH_HASH) begin
						ps = ST_NF;
					end else begin
						done = 1'b1;
					end
				end else if (c inside {[8'h30:8'h3F]}) begin
					done = 1'b1;
				end else if (c inside {[8'h40:CH_APC]}) begin
					if (c == CH_CSI) begin
						ps = ST_CSI1;
					end else if (c inside {CH_SS2, CH_SS3}) begin
						ps = ST_SS;
					end else if (c inside {CH_DCS, CH_SOS, CH_OSC, CH_PM, CH_APC}) begin
						ps = ST_STR;
					end else begin
						done = 1'b1;
					end
				end else if (c == CH_ESC) begin
					// esc mashing
					if (cnt >= CNT_3) begin
						cnt  = CNT_ONE;
						done = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
			end
			ST_SS: begin
				done = 1'b1;
			end
			ST_NF: begin
				if (c inside {[8'h30:CH_TILDE]}) begin
					done = 1'b1;
				end else if (!(c inside {[CH_SP:8'h2F]})) begin
					restart = 1'b1;
				end
			end
			ST_CSI1: begin
				if (c inside {[CH_SP:8'h2F]}) begin
					ps = ST_CSI2;
				end else if (c == CH_CSI && (cnt == CNT_3 || (cnt == CNT_4 && second_esc))) begin
					// linux function keys stay open
					ps = ST_CSI1;
				end else if (c inside {[8'h40:CH_TILDE]}) begin
					done = 1'b1;
				end else if (!(c inside {[8'h30:8'h3F]})) begin
					restart = 1'b1;
				end
			end
			ST_CSI2: begin
				if (c inside {[8'h40:CH_TILDE]}) begin
					done = 1'b1;
				end else if (!(c inside {[CH_SP:8'h2F]})) begin
					restart = 1'b1;
				end
			end
			ST_STR: begin
				if (c == CH_BEL) begin
					done = 1'b1;
				end else if (c == CH_ESC || c == CH_C2_LEAD) begin
					ps = ST_STR2;
				end
			end
			default: begin
				if (c == CH_BEL || c == CH_ST || c == CH_C1_ST) begin
					done = 1'b1;
				end else begin
					ps = ST_STR;
				end
			end
		endcase

		// illegal byte starts a new sequence
		if (restart) begin
			ps  = ST_PLAIN;
			cnt = CNT_ONE;
			if (c == CH_ESC) begin
				ps = ST_ESC;
			end else if (c < CH_C1_LO || c >= CH_UTF8_LO) begin
				done = 1'b1;
			end
		end

		if (word.kind == KIND_END || done) begin
			state_next      = ST_PLAIN;
			count_next      = '0;
			second_esc_next = 1'b0;
		end else begin
			state_next      = ps;
			count_next      = cnt;
			second_esc_next = (cnt == CNT_TWO) ? (c == CH_ESC) : second_esc;
		end
	end

	// result word
	always_comb begin
		cnt_ext = (word.kind == KIND_END) ? 32'(count) : 32'(cnt);
		len     = (cnt_ext > 32'(LEN_MAX)) ? LEN_MAX : cnt_ext[15:0];
		if (word.kind == KIND_END) begin
			result.result_code = (count == '0) ? RC_EMPTY : RC_TRUNC;
			result.seq_length  = (count == '0) ? 16'd0 : len;
			result.restarted   = 1'b0;
		end else begin
			result.result_code = done ? RC_DONE : RC_BUSY;
			result.seq_length  = len;
			result.restarted   = restart;
		end
	end

endmodule

/* rtl/ansi_escape_sequence_framer.sv */
`timescale 1ns / 1ps

// escape sequence framer for a terminal input byte stream
// rx channel: one word per byte (kind = data) or an end-of-input marker (kind = end)
// frame channel: one word back for every rx word, in order
//   result_code busy while a sequence is open, done on its last byte,
//   empty or truncated for end of input; seq_length is the running byte count
// path: an rx word goes into the input register, then into the result register,
//   which drives frame_valid until frame_ready takes the word
// throughput: one word per cycle unless frame_ready stalls; parse state, byte count
//   and second-byte flag change in the same cycle the word enters the result register
// a held frame word does not stop the next rx word being taken into the input
//   register; rx_ready drops only while both registers are full and frame_ready is low
// reset clears both registers' valid flags and returns the parser to the plain
//   byte state with a zero count
// COUNT_WIDTH sets the saturating byte counter; seq_length saturates at 65535

module ansi_escape_sequence_framer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  aesf_pkg::rx_word_t    rx_word,
	output logic                  frame_valid,
	input  logic                  frame_ready,
	output aesf_pkg::frame_word_t frame_word
);
	import aesf_pkg::*;

	logic                   valid_s1;
	rx_word_t               word_s1;
	logic                   valid_s2;
	frame_word_t            word_s2;
	logic                   advance;
	parse_state_t           state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   second_esc_q;
	parse_state_t           state_next;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   second_esc_next;
	frame_word_t            result;

	assign advance     = valid_s1 && (!valid_s2 || frame_ready);
	assign rx_ready    = !valid_s1 || advance;
	assign frame_valid = valid_s2;
	assign frame_word  = word_s2;

	aesf_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.word           (word_s1),
		.state          (state_q),
		.count          (count_q),
		.second_esc     (second_esc_q),
		.state_next     (state_next),
		.count_next     (count_next),
		.second_esc_next(second_esc_next),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			state_q      <= ST_PLAIN;
			count_q      <= '0;
			second_esc_q <= 1'b0;
		end else begin
			if (rx_ready) begin
				valid_s1 <= rx_valid;
			end
			if (advance) begin
				valid_s2     <= 1'b1;
				state_q      <= state_next;
				count_q      <= count_next;
				second_esc_q <= second_esc_next;
			end else if (frame_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			word_s1 <= rx_word;
		end
		if (advance) begin
			word_s2 <= result;
		end
	end

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.result_code != RC_BUSY |=> state_q == ST_PLAIN && count_q == '0)
		else $error("parser not cleared after a finished sequence");

	a_restart_len: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.restarted |-> result.seq_length == 16'd1)
		else $error("restarted sequence does not have length one");

	a_end_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.kind == KIND_END |-> !result.restarted &&
		(result.result_code == RC_EMPTY || result.result_code == RC_TRUNC))
		else $error("end of input gave a wrong result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> rx_ready)
		else $error("rx stalled with an empty result register");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(count_q))
		else $error("parser state moved without a word");

endmodule

/* tb/tb_ansi_escape_sequence_framer.sv */
`timescale 1ns / 1ps

module tb_ansi_escape_sequence_framer;
	import aesf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	rx_word_t    rx_word = '0;
	logic        frame_valid;
	logic        frame_ready = 1'b0;
	frame_word_t frame_word;

	rx_word_t    rx_pending[$];
	frame_word_t frames_due[$];

	parse_state_t psr_state = ST_PLAIN;
	logic [15:0]  psr_count = '0;
	logic         psr_second_esc = 1'b0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  words_in = 0;
	int  n_queued = 0;
	int  err_cnt = 0;
	logic rx_fire = 1'b0;
	int  hold_left = 0;
	logic hold_done = 1'b0;

	ansi_escape_sequence_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_word(rx_word),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_word(frame_word)
	);

	always #1 clk = ~clk;

	function automatic logic in_span(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
		return c >= lo && c <= hi;
	endfunction

	function automatic logic plain_step(logic [7:0] c);
		if (c < CH_C1_LO) begin
			if (c == CH_ESC) begin
				psr_state = ST_ESC;
				return 1'b0;
			end
			return 1'b1;
		end
		return c >= CH_UTF8_LO;
	endfunction

	function automatic void parser_clear();
		psr_state = ST_PLAIN;
		psr_count = '0;
		psr_second_esc = 1'b0;
	endfunction

	function automatic frame_word_t advance_parser(rx_word_t w);
		frame_word_t r;
		logic [7:0]  c;
		logic        done;
		logic        restart;
		c = w.byte_value;
		done = 1'b0;
		restart = 1'b0;
		r = '0;
		if (w.kind == KIND_END) begin
			r.result_code = (psr_count == 0) ? RC_EMPTY : RC_TRUNC;
			r.seq_length = psr_count;
			r.restarted = 1'b0;
			parser_clear();
			return r;
		end
		if (psr_count != LEN_MAX)
			psr_count = psr_count + 1'b1;
		case (psr_state)
			ST_PLAIN: begin
				done = plain_step(c);
			end
			ST_ESC: begin
				if (in_span(c, 8'h20, 8'h2F)) begin
					if (c == CH_SP || c == CH_HASH)
						psr_state = ST_NF;
					else
						done = 1'b1;
				end else if (in_span(c, 8'h30, 8'h3F)) begin
					done = 1'b1;
				end else if (in_span(c, 8'h40, CH_APC)) begin
					if (c == CH_CSI)
						psr_state = ST_CSI1;
					else if (c == CH_SS2 || c == CH_SS3)
						psr_state = ST_SS;
					else if (c == CH_DCS || c == CH_SOS || c == CH_OSC || c == CH_PM ||
							c == CH_APC)
						psr_state = ST_STR;
					else
						done = 1'b1;
				end else if (c == CH_ESC) begin
					if (psr_count >= 3) begin
						psr_count = 16'd1;
						done = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
			end
			ST_SS: begin
				done = 1'b1;
			end
			ST_NF: begin
				if (in_span(c, 8'h30, CH_TILDE))
					done = 1'b1;
				else if (!in_span(c, 8'h20, 8'h2F))
					restart = 1'b1;
			end
			ST_CSI1: begin
				if (in_span(c, 8'h20, 8'h2F))
					psr_state = ST_CSI2;
				else if (c == CH_CSI &&
						(psr_count == 3 || (psr_count == 4 && psr_second_esc)))
					done = 1'b0;
				else if (in_span(c, 8'h40, CH_TILDE))
					done = 1'b1;
				else if (!in_span(c, 8'h30, 8'h3F))
					restart = 1'b1;
			end
			ST_CSI2: begin
				if (in_span(c, 8'h40, CH_TILDE))
					done = 1'b1;
				else if (!in_span(c, 8'h20, 8'h2F))
					restart = 1'b1;
			end
			ST_STR: begin
				if (c == CH_BEL)
					done = 1'b1;
				else if (c == CH_ESC || c == CH_C2_LEAD)
					psr_state = ST_STR2;
			end
			default: begin
				if (c == CH_BEL || c == CH_ST || c == CH_C1_ST)
					done = 1'b1;
				else
					psr_state = ST_STR;
			end
		endcase
		if (restart) begin
			psr_state = ST_PLAIN;
			psr_count = 16'd1;
			done = plain_step(c);
		end
		if (psr_count == 2)
			psr_second_esc = (c == CH_ESC);
		r.result_code = done ? RC_DONE : RC_BUSY;
		r.seq_length = psr_count;
		r.restarted = restart;
		if (done)
			parser_clear();
		return r;
	endfunction

	task automatic push_byte(logic [7:0] b);
		rx_word_t w;
		w.kind = KIND_DATA;
		w.byte_value = b;
		rx_pending.push_back(w);
		n_queued++;
	endtask

	task automatic push_end();
		rx_word_t w;
		w.kind = KIND_END;
		w.byte_value = 8'($urandom_range(255));
		rx_pending.push_back(w);
		n_queued++;
	endtask

	task automatic push_rand(int lo, int hi);
		push_byte(8'($urandom_range(hi, lo)));
	endtask

	task automatic add_sequence();
		int sel;
		int n;
		sel = $urandom_range(99);
		if (sel < 10) begin
			push_rand(0, 255);
		end else if (sel < 20) begin
			push_byte(CH_ESC);
			push_rand(0, 255);
		end else if (sel < 45) begin
			push_byte(CH_ESC);
			push_byte(CH_CSI);
			if ($urandom_range(7) == 0) begin
				push_byte(CH_CSI);
				push_rand(8'h41, 8'h45);
			end else begin
				n = $urandom_range(4);
				repeat (n) push_rand(8'h30, 8'h3F);
				n = $urandom_range(2);
				repeat (n) push_rand(8'h20, 8'h2F);
				if ($urandom_range(9) == 0)
					push_rand(0, 255);
				else
					push_rand(8'h40, 8'h7E);
			end
		end else if (sel < 53) begin
			push_byte(CH_ESC);
			push_byte($urandom_range(1) ? CH_SS2 : CH_SS3);
			push_rand(0, 255);
		end else if (sel < 61) begin
			push_byte(CH_ESC);
			push_byte($urandom_range(1) ? CH_SP : CH_HASH);
			n = $urandom_range(2);
			repeat (n) push_rand(8'h20, 8'h2F);
			if ($urandom_range(9) == 0)
				push_rand(0, 255);
			else
				push_rand(8'h30, 8'h7E);
		end else if (sel < 81) begin
			push_byte(CH_ESC);
			case ($urandom_range(4))
				0: push_byte(CH_DCS);
				1: push_byte(CH_SOS);
				2: push_byte(CH_OSC);
				3: push_byte(CH_PM);
				default: push_byte(CH_APC);
			endcase
			n = $urandom_range(12);
			repeat (n) begin
				if ($urandom_range(7) == 0)
					push_rand(0, 255);
				else
					push_rand(8'h20, 8'h7E);
			end
			case ($urandom_range(3))
				0: push_byte(CH_BEL);
				1: begin
					push_byte(CH_ESC);
					push_byte(CH_ST);
				end
				2: begin
					push_byte(CH_C2_LEAD);
					push_byte(CH_C1_ST);
				end
				default: begin
					push_byte(CH_ESC);
					push_rand(0, 255);
				end
			endcase
		end else if (sel < 86) begin
			push_byte(CH_ESC);
			push_byte(CH_ESC);
			if ($urandom_range(1)) begin
				push_byte(CH_CSI);
				push_byte(CH_CSI);
				push_rand(8'h41, 8'h45);
			end else begin
				push_byte(CH_ESC);
			end
		end else if (sel < 91) begin
			n = $urandom_range(3, 1);
			repeat (n) push_rand(8'h80, 8'hBF);
			push_rand(0, 255);
		end else if (sel < 96) begin
			push_end();
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) push_rand(0, 255);
		end
	endtask

	task automatic drain();
		while (rx_pending.size() != 0 || rx_valid || frames_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = n_queued + count;
		while (n_queued < target)
			add_sequence();
		drain();
	endtask

	always @(posedge clk) begin
		frame_word_t want;
		rx_fire <= arst_n && rx_valid && rx_ready;
		if (arst_n && rx_valid && rx_ready) begin
			frames_due.push_back(advance_parser(rx_word));
			words_in <= words_in + 1;
		end
		if (arst_n && frame_valid && frame_ready) begin
			if (frames_due.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected frame word: code %0d len %0d restarted %0b",
						frame_word.result_code, frame_word.seq_length,
						frame_word.restarted);
				err_cnt++;
			end else begin
				want = frames_due.pop_front();
				if (frame_word.result_code !== want.result_code ||
						frame_word.seq_length !== want.seq_length ||
						frame_word.restarted !== want.restarted) begin
					if (err_cnt < 10)
						$display({"frame mismatch: want code %0d len %0d restarted %0b,",
							" got code %0d len %0d restarted %0b"},
							want.result_code, want.seq_length, want.restarted,
							frame_word.result_code, frame_word.seq_length,
							frame_word.restarted);
					err_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || rx_fire) begin
			if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rx_word <= rx_pending.pop_front();
				rx_valid <= 1'b1;
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// long back-pressure once so the input side fills and stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_ready <= 1'b0;
		end else if (hold_left != 0) begin
			frame_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_in >= 200) begin
			frame_ready <= 1'b0;
			hold_left <= 80;
			hold_done <= 1'b1;
		end else begin
			frame_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_end();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'hBF);
		push_byte(8'h41);
		push_byte(CH_ESC);
		push_byte(CH_ESC);
		push_byte(CH_ESC);
		push_byte(CH_ESC);
		push_byte(CH_ESC);
		push_byte(CH_CSI);
		push_byte(CH_CSI);
		push_byte(8'h41);
		push_byte(CH_ESC);
		push_byte(CH_CSI);
		push_byte(8'h00);
		push_byte(CH_ESC);
		push_byte(CH_HASH);
		push_byte(CH_ESC);
		push_end();
		push_byte(CH_ESC);
		push_byte(CH_OSC);
		push_byte(CH_C2_LEAD);
		push_byte(CH_C1_ST);

		run_phase(0, 0, 475);
		run_phase(48, 0, 475);
		run_phase(0, 48, 475);
		run_phase(20, 20, 475);

		repeat (10) @(posedge clk);
		if (err_cnt == 0 && frames_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
